/* design/dtw_pkg.sv */
// Shared definitions for the dual timer with watchdog: bus function codes,
// register offsets, control-field positions and watchdog keys.
// No dependencies.
package dtw_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 32;

  // Stream payload widths.
  localparam int S_TDATA_W = 40;  // reg_index, write_data, zero pad
  localparam int S_TUSER_W = 2;   // func
  localparam int M_TDATA_W = 32;  // read_data
  localparam int M_TUSER_W = 3;   // irq_low, irq_high, watchdog_reset

  // Function codes carried in s_tuser.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Register word offsets.
  localparam logic [3:0] REG_ID      = 4'd0;
  localparam logic [3:0] REG_CNT_LO  = 4'd4;
  localparam logic [3:0] REG_CNT_HI  = 4'd5;
  localparam logic [3:0] REG_PRD_LO  = 4'd6;
  localparam logic [3:0] REG_PRD_HI  = 4'd7;
  localparam logic [3:0] REG_TCR     = 4'd8;
  localparam logic [3:0] REG_TGCR    = 4'd9;
  localparam logic [3:0] REG_WDTCR   = 4'd10;

  // Control field positions.
  localparam int LOW_MODE_SHIFT  = 6;
  localparam int HIGH_MODE_SHIFT = 22;
  localparam int WDEN_BIT        = 14;
  localparam int KEY_SHIFT       = 16;

  // Per-half enable modes in TCR.
  localparam logic [1:0] EN_DISABLED = 2'd0;
  localparam logic [1:0] EN_ONESHOT  = 2'd1;
  localparam logic [1:0] EN_PERIODIC = 2'd2;

  // Timer modes in TGCR bits 3:2.
  localparam logic [1:0] TMODE_UNCHAINED = 2'd1;
  localparam logic [1:0] TMODE_WATCHDOG  = 2'd2;

  // Watchdog keys.
  localparam logic [15:0] KEY_ARM = 16'ha5c6;
  localparam logic [15:0] KEY_GO  = 16'hda7e;

endpackage

/* design/dual_timer_with_watchdog.sv */
// Dual timer with keyed watchdog: register file, two counters and the
// watchdog sequencer in one module. Depends on dtw_pkg.
//
// Each input transfer loads its result into the result register.
// Throughput: one item per cycle; the result register frees as it drains,
// so a new input is taken while m_tready is high or the register is empty.
// Reset (rst, synchronous, active high) zeroes every counter, period and
// control register, returns the watchdog to idle and empties the result
// register. A watchdog timeout or key violation does the same to the
// register state in the cycle of its result.
module dual_timer_with_watchdog #(
  parameter int COUNT_WIDTH = dtw_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dtw_pkg::S_TDATA_W-1:0] s_tdata,   // [3:0] reg_index, [35:4] write_data,
                                                   // [39:36] zero
  input  logic [dtw_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] func
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dtw_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] read_data
  output logic [dtw_pkg::M_TUSER_W-1:0] m_tuser    // [0] irq_low, [1] irq_high,
                                                   // [2] watchdog_reset
);
  import dtw_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRE,
    PH_ACTIVE,
    PH_SERVICE
  } phase_t;

  // Architectural state.
  logic [CW-1:0] count_low, count_high, period_low, period_high;
  logic [31:0]   timer_control;
  logic [3:0]    global_control;
  logic          watchdog_enable;
  phase_t        watchdog_phase;

  logic [CW-1:0] count_low_next, count_high_next, period_low_next, period_high_next;
  logic [31:0]   timer_control_next;
  logic [3:0]    global_control_next;
  logic          watchdog_enable_next;
  phase_t        watchdog_phase_next;

  // Result of the item being taken this cycle.
  logic [31:0] rd;
  logic        il, ih, wr;

  // Unpacked input fields.
  logic [1:0]  func;
  logic [3:0]  reg_index;
  logic [31:0] write_data;
  logic [15:0] key;
  logic        wden_eff;
  logic        accept;

  assign func       = s_tuser[1:0];
  assign reg_index  = s_tdata[3:0];
  assign write_data = s_tdata[35:4];
  assign key        = write_data[KEY_SHIFT +: 16];
  assign wden_eff   = watchdog_enable | write_data[WDEN_BIT];

  // Take a new item whenever the result register is empty or draining.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    count_low_next       = count_low;
    count_high_next      = count_high;
    period_low_next      = period_low;
    period_high_next     = period_high;
    timer_control_next   = timer_control;
    global_control_next  = global_control;
    watchdog_enable_next = watchdog_enable;
    watchdog_phase_next  = watchdog_phase;
    rd = '0;
    il = 1'b0;
    ih = 1'b0;
    wr = 1'b0;

    case (func)
      FUNC_TICK: begin
        if (global_control[3:2] == TMODE_UNCHAINED) begin
          // Low half: match pulses and returns to zero; one-shot disables itself.
          if (global_control[0] &&
              timer_control[LOW_MODE_SHIFT +: 2] != EN_DISABLED) begin
            if (count_low == period_low) begin
              count_low_next = '0;
              il = 1'b1;
              if (timer_control[LOW_MODE_SHIFT +: 2] == EN_ONESHOT) begin
                timer_control_next[LOW_MODE_SHIFT +: 2] = EN_DISABLED;
              end
            end else begin
              count_low_next = count_low + 1'b1;
            end
          end
          // High half, same rules.
          if (global_control[1] &&
              timer_control[HIGH_MODE_SHIFT +: 2] != EN_DISABLED) begin
            if (count_high == period_high) begin
              count_high_next = '0;
              ih = 1'b1;
              if (timer_control[HIGH_MODE_SHIFT +: 2] == EN_ONESHOT) begin
                timer_control_next[HIGH_MODE_SHIFT +: 2] = EN_DISABLED;
              end
            end else begin
              count_high_next = count_high + 1'b1;
            end
          end
        end else if (global_control[3:2] == TMODE_WATCHDOG &&
                     global_control[1:0] == 2'b11 &&
                     (watchdog_phase == PH_ACTIVE || watchdog_phase == PH_SERVICE)) begin
          // Both halves count as one wide value; timeout on a full match.
          if (count_low == period_low && count_high == period_high) begin
            wr = 1'b1;
          end else if (count_low == CNT_MAX) begin
            count_low_next  = '0;
            count_high_next = count_high + 1'b1;
          end else begin
            count_low_next = count_low + 1'b1;
          end
        end
      end
      FUNC_READ: begin
        case (reg_index)
          REG_CNT_LO: rd = 32'(count_low);
          REG_CNT_HI: rd = 32'(count_high);
          REG_PRD_LO: rd = 32'(period_low);
          REG_PRD_HI: rd = 32'(period_high);
          REG_TCR:    rd = timer_control;
          REG_TGCR:   rd = 32'(global_control);
          REG_WDTCR:  rd = 32'(watchdog_enable) << WDEN_BIT;
          default:    rd = '0;  // id and unmapped offsets read as zero
        endcase
      end
      FUNC_WRITE: begin
        case (reg_index)
          REG_CNT_LO: count_low_next      = write_data[CW-1:0];
          REG_CNT_HI: count_high_next     = write_data[CW-1:0];
          REG_PRD_LO: period_low_next     = write_data[CW-1:0];
          REG_PRD_HI: period_high_next    = write_data[CW-1:0];
          REG_TCR:    timer_control_next  = write_data;
          REG_TGCR:   global_control_next = write_data[3:0];
          REG_WDTCR: begin
            // WDEN sticks until reset or a watchdog reset; keys count only once it is set.
            watchdog_enable_next = wden_eff;
            if (wden_eff) begin
              case (watchdog_phase)
                PH_IDLE: begin
                  if (key == KEY_ARM) watchdog_phase_next = PH_PRE;
                end
                PH_PRE: begin
                  if (key == KEY_GO) watchdog_phase_next = PH_ACTIVE;
                end
                PH_ACTIVE: begin
                  if (key == KEY_ARM) watchdog_phase_next = PH_SERVICE;
                  else wr = 1'b1;
                end
                PH_SERVICE: begin
                  // Service completes: restart the count.
                  if (key == KEY_GO) begin
                    count_low_next      = '0;
                    count_high_next     = '0;
                    watchdog_phase_next = PH_ACTIVE;
                  end else begin
                    wr = 1'b1;
                  end
                end
                default: watchdog_phase_next = PH_IDLE;
              endcase
            end
          end
          default: ;  // id and unmapped offsets ignore writes
        endcase
      end
      default: ;  // unused function code: no effect
    endcase

    // Timeout or violation: return the whole unit to its reset values.
    if (wr) begin
      count_low_next       = '0;
      count_high_next      = '0;
      period_low_next      = '0;
      period_high_next     = '0;
      timer_control_next   = '0;
      global_control_next  = '0;
      watchdog_enable_next = 1'b0;
      watchdog_phase_next  = PH_IDLE;
    end
  end

  // Commit state on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_low       <= '0;
      count_high      <= '0;
      period_low      <= '0;
      period_high     <= '0;
      timer_control   <= '0;
      global_control  <= '0;
      watchdog_enable <= 1'b0;
      watchdog_phase  <= PH_IDLE;
    end else if (accept) begin
      count_low       <= count_low_next;
      count_high      <= count_high_next;
      period_low      <= period_low_next;
      period_high     <= period_high_next;
      timer_control   <= timer_control_next;
      global_control  <= global_control_next;
      watchdog_enable <= watchdog_enable_next;
      watchdog_phase  <= watchdog_phase_next;
    end
  end

  // Result register: load on an input transfer, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= rd;
      m_tuser <= {wr, ih, il};
    end
  end

endmodule

/* design/dtw_checker.sv */
// Port-level checks for dual_timer_with_watchdog, attached by bind.
// Depends on dtw_pkg and the top level's port list.
module dtw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dtw_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [dtw_pkg::M_TUSER_W-1:0] m_tuser
);
  import dtw_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Every input transfer yields a result on the next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("input transfer produced no result");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Read data comes only from reads, which raise no pulse.
  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata != '0 |-> m_tuser == '0)
    else $error("pulse on a read result");

  // Watchdog reset never coincides with a timer interrupt.
  a_wdt_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == 2'b00 && m_tdata == '0)
    else $error("watchdog reset with interrupt or read data");

endmodule

bind dual_timer_with_watchdog dtw_checker u_dtw_checker (.*);

/* dv/testbench.sv */
// Stream-level testbench for dual_timer_with_watchdog: register reads, writes and
// clock ticks go in, and every result is checked against a shadow model of the
// two counters and the keyed watchdog. Depends on dtw_pkg and the RTL top module.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dtw_pkg::*;

  localparam int          CW            = COUNT_WIDTH_DEFAULT;
  localparam logic [31:0] COUNT_MASK    = 32'((64'd1 << CW) - 64'd1);
  localparam int          RANDOM_ITEMS  = 750;
  localparam int          CYCLE_LIMIT   = 200_000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          PRINT_LIMIT   = 25;
  // func 3 has no meaning in the block; the package leaves it unnamed
  localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
  localparam logic [3:0]  REG_UNMAPPED  = 4'd15;
  localparam logic [15:0] KEY_BAD       = 16'h5a5a;

  typedef enum logic [1:0] {
    WD_IDLE,
    WD_PRE,
    WD_ACTIVE,
    WD_SERVICE
  } wd_state_t;

  // One result transfer, split into its fields.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_low;
    logic        irq_high;
    logic        watchdog_reset;
  } timer_result_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [S_TUSER_W-1:0] s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  // Shadow copy of the register state, advanced once per accepted input.
  logic [31:0] t0_count, t1_count, t0_period, t1_period;
  logic [31:0] tcr_shadow;
  logic [3:0]  tgcr_shadow;
  logic        wd_enabled;
  wd_state_t   wd_state;

  timer_result_t pending_results[$];

  // Idle controls; the random traffic test steps through several settings.
  int sender_gap_pct = 0;
  int stall_pct      = 0;

  int error_count    = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int irq_events     = 0;
  int wd_resets      = 0;
  int cycle_count    = 0;

  always #6 clk = ~clk;

  dual_timer_with_watchdog dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // Return every register to its power-up value; a watchdog bite does the same.
  function automatic void clear_shadow();
    t0_count    = '0;
    t1_count    = '0;
    t0_period   = '0;
    t1_period   = '0;
    tcr_shadow  = '0;
    tgcr_shadow = '0;
    wd_enabled  = 1'b0;
    wd_state    = WD_IDLE;
  endfunction

  // Advance one free-running half; a match pulses the interrupt and wraps to
  // zero, and a one-shot half also switches itself off.
  function automatic logic advance_half(inout logic [31:0] count,
                                        input logic [31:0] period, input int shift);
    logic [1:0] mode;
    mode = tcr_shadow[shift +: 2];
    if (mode == EN_DISABLED) begin
      return 1'b0;
    end
    if (count == period) begin
      count = '0;
      if (mode == EN_ONESHOT) begin
        tcr_shadow[shift +: 2] = EN_DISABLED;
      end
      return 1'b1;
    end
    count = (count + 32'd1) & COUNT_MASK;
    return 1'b0;
  endfunction

  // Step the key sequencer on a WDTCR write; true means a key violation.
  function automatic logic apply_wd_key(logic [31:0] value);
    logic [15:0] key;
    key = value[KEY_SHIFT +: 16];
    if (value[WDEN_BIT]) begin
      wd_enabled = 1'b1;
    end
    if (!wd_enabled) begin
      return 1'b0;
    end
    case (wd_state)
      WD_IDLE: begin
        if (key == KEY_ARM) wd_state = WD_PRE;
        return 1'b0;
      end
      WD_PRE: begin
        if (key == KEY_GO) wd_state = WD_ACTIVE;
        return 1'b0;
      end
      WD_ACTIVE: begin
        if (key == KEY_ARM) begin
          wd_state = WD_SERVICE;
          return 1'b0;
        end
        return 1'b1;
      end
      default: begin
        if (key == KEY_GO) begin
          // servicing the dog restarts the 64-bit count
          t0_count = '0;
          t1_count = '0;
          wd_state = WD_ACTIVE;
          return 1'b0;
        end
        return 1'b1;
      end
    endcase
  endfunction

  function automatic timer_result_t predict_timer(logic [1:0] func, logic [3:0] idx,
                                                  logic [31:0] value);
    timer_result_t r;
    r = '0;
    case (func)
      FUNC_TICK: begin
        if (tgcr_shadow[3:2] == TMODE_UNCHAINED) begin
          if (tgcr_shadow[0]) r.irq_low  = advance_half(t0_count, t0_period, LOW_MODE_SHIFT);
          if (tgcr_shadow[1]) r.irq_high = advance_half(t1_count, t1_period, HIGH_MODE_SHIFT);
        end else if (tgcr_shadow[3:2] == TMODE_WATCHDOG && tgcr_shadow[1:0] == 2'b11 &&
                     (wd_state == WD_ACTIVE || wd_state == WD_SERVICE)) begin
          // timeout is checked before the count moves
          if (t0_count == t0_period && t1_count == t1_period) begin
            r.watchdog_reset = 1'b1;
          end else if (t0_count == COUNT_MASK) begin
            t0_count = '0;
            t1_count = (t1_count + 32'd1) & COUNT_MASK;
          end else begin
            t0_count = t0_count + 32'd1;
          end
        end
      end
      FUNC_READ: begin
        case (idx)
          REG_CNT_LO: r.read_data = t0_count;
          REG_CNT_HI: r.read_data = t1_count;
          REG_PRD_LO: r.read_data = t0_period;
          REG_PRD_HI: r.read_data = t1_period;
          REG_TCR:    r.read_data = tcr_shadow;
          REG_TGCR:   r.read_data = {28'd0, tgcr_shadow};
          REG_WDTCR:  r.read_data[WDEN_BIT] = wd_enabled;
          default:    r.read_data = '0;
        endcase
      end
      FUNC_WRITE: begin
        case (idx)
          REG_CNT_LO: t0_count    = value & COUNT_MASK;
          REG_CNT_HI: t1_count    = value & COUNT_MASK;
          REG_PRD_LO: t0_period   = value & COUNT_MASK;
          REG_PRD_HI: t1_period   = value & COUNT_MASK;
          REG_TCR:    tcr_shadow  = value;
          REG_TGCR:   tgcr_shadow = value[3:0];
          REG_WDTCR:  r.watchdog_reset = apply_wd_key(value);
          default: ;
        endcase
      end
      default: ;
    endcase
    if (r.watchdog_reset) begin
      clear_shadow();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Present one item, hold it until the transfer, then log its expected result.
  task automatic send_item(logic [1:0] func, logic [3:0] idx, logic [31:0] value);
    while ($urandom_range(1, 100) <= sender_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= S_TDATA_W'({value, idx});
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_timer(func, idx, value));
    items_sent++;
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] value);
    send_item(FUNC_WRITE, idx, value);
  endtask

  task automatic read_reg(logic [3:0] idx);
    send_item(FUNC_READ, idx, $urandom);
  endtask

  task automatic tick(int n);
    repeat (n) send_item(FUNC_TICK, 4'($urandom), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the result check
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h (result %0d)",
               $realtime, field, got, want, results_seen);
    end
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", m_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.read_data) report_mismatch("read_data", m_tdata, want.read_data);
        if (m_tuser[0] !== want.irq_low) begin
          report_mismatch("irq_low", 32'(m_tuser[0]), 32'(want.irq_low));
        end
        if (m_tuser[1] !== want.irq_high) begin
          report_mismatch("irq_high", 32'(m_tuser[1]), 32'(want.irq_high));
        end
        if (m_tuser[2] !== want.watchdog_reset) begin
          report_mismatch("watchdog_reset", 32'(m_tuser[2]), 32'(want.watchdog_reset));
        end
        if (want.irq_low || want.irq_high) irq_events++;
        if (want.watchdog_reset) wd_resets++;
      end
      results_seen++;
    end
    m_tready <= ($urandom_range(1, 100) > stall_pct);
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Width trimming, unmapped offsets, the unused function code and a tick in
  // a mode that never counts.
  task automatic test_register_access();
    write_reg(REG_CNT_LO, 32'hffff_ffff);
    write_reg(REG_TGCR, 32'hffff_ffff);     // keeps 4 bits: mode 3, both released
    tick(1);                                // mode 3 ignores ticks
    read_reg(REG_TGCR);
    write_reg(REG_UNMAPPED, 32'hffff_ffff); // dropped
    read_reg(REG_ID);
    send_item(FUNC_UNUSED, REG_UNMAPPED, 32'hffff_ffff);
  endtask

  // Low half periodic from a count above its period (wraps before matching),
  // high half one-shot with period zero (matches once, then turns off).
  task automatic test_unchained_counting();
    write_reg(REG_PRD_LO, 32'd1);
    write_reg(REG_TCR, (32'(EN_PERIODIC) << LOW_MODE_SHIFT) |
                       (32'(EN_ONESHOT) << HIGH_MODE_SHIFT));
    write_reg(REG_TGCR, {28'd0, TMODE_UNCHAINED, 2'b11});
    tick(4);
    read_reg(REG_TCR);                      // high mode field now cleared
  endtask

  // Key sequence without and with WDEN, service, timeout and a key violation.
  task automatic test_watchdog_sequence();
    write_reg(REG_WDTCR, {KEY_ARM, 16'h0000});                  // WDEN clear: ignored
    write_reg(REG_TGCR, {28'd0, TMODE_WATCHDOG, 2'b11});
    tick(1);                                                    // idle dog holds the count
    write_reg(REG_WDTCR, {KEY_ARM, 16'h0000} | (32'd1 << WDEN_BIT));
    write_reg(REG_WDTCR, {KEY_GO, 16'h0000});
    write_reg(REG_WDTCR, {KEY_ARM, 16'h0000});                  // active -> service
    write_reg(REG_WDTCR, {KEY_GO, 16'h0000});                   // clears both counts
    tick(2);                                                    // second tick times out
    write_reg(REG_WDTCR, {KEY_ARM, 16'h0000} | (32'd1 << WDEN_BIT));
    write_reg(REG_WDTCR, {KEY_GO, 16'hffff});
    write_reg(REG_WDTCR, {KEY_BAD, 16'h0000});                  // violation
  endtask

  // Counter and period values: mostly small so matches and timeouts happen.
  function automatic logic [31:0] count_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return 32'($urandom_range(0, 12));
    if (pick < 85) return COUNT_MASK - 32'($urandom_range(0, 3));
    return $urandom;
  endfunction

  task automatic send_random_item();
    int          pick;
    logic [31:0] value;
    logic [15:0] key;
    pick  = $urandom_range(0, 99);
    value = $urandom;
    if (pick < 45) begin
      tick(1);
    end else if (pick < 58) begin
      read_reg(4'($urandom));
    end else if (pick < 60) begin
      send_item(FUNC_UNUSED, 4'($urandom), value);
    end else if (pick < 63) begin
      write_reg(4'($urandom), value);
    end else if (pick < 71) begin
      write_reg($urandom_range(0, 1) ? REG_CNT_LO : REG_CNT_HI, count_value());
    end else if (pick < 79) begin
      write_reg($urandom_range(0, 1) ? REG_PRD_LO : REG_PRD_HI, count_value());
    end else if (pick < 83) begin
      write_reg(REG_TCR, value);
    end else if (pick < 88) begin
      // favor the two modes that count; leave garbage in the dropped bits
      case ($urandom_range(0, 2))
        0: value[3:0] = {TMODE_UNCHAINED, 2'b11};
        1: value[3:0] = {TMODE_WATCHDOG, 2'b11};
        default: ;
      endcase
      write_reg(REG_TGCR, value);
    end else begin
      pick = $urandom_range(0, 99);
      key  = (pick < 45) ? KEY_ARM : (pick < 85) ? KEY_GO : 16'($urandom);
      value[31:16]    = key;
      value[WDEN_BIT] = ($urandom_range(0, 99) < 70);
      write_reg(REG_WDTCR, value);
    end
  endtask

  task automatic test_random_traffic();
    int gaps[4]   = '{0, 52, 0, 8};
    int stalls[4] = '{0, 0, 52, 8};
    for (int p = 0; p < 4; p++) begin
      sender_gap_pct = gaps[p];
      stall_pct      = stalls[p];
      repeat (RANDOM_ITEMS / 4) send_random_item();
    end
  endtask

  initial begin
    clear_shadow();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_register_access();
    test_unchained_counting();
    test_watchdog_sequence();
    test_random_traffic();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items, checked %0d results: %0d timer interrupts, %0d watchdog bites",
             items_sent, results_seen, irq_events, wd_resets);
    $display("idle settings covered: none, sender gaps, receiver stalls, both; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
